// ===== src/tilt_average_zoom_angles_macros.svh =====
// ----------------------------------------------------------------------------
// Tilt average zoom angles: assertion macros
// Shared property shorthands for the checker that watches the block's ports.
// ----------------------------------------------------------------------------
`ifndef TILT_AVERAGE_ZOOM_ANGLES_MACROS_SVH
`define TILT_AVERAGE_ZOOM_ANGLES_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TAZA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TAZA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/taza_pkg.sv =====
// ----------------------------------------------------------------------------
// Tilt average zoom angles: package
// Beat types, operation flags and fixed constants shared by the block.
// ----------------------------------------------------------------------------
package taza_pkg;

  // Ring geometry.
  localparam int RING_DEPTH = 32;
  localparam int RING_AW    = 5;

  // Tilt arithmetic: gain of 420 in Q.12.
  localparam int TILT_GAIN  = 420;
  localparam int FRAC_SHIFT = 12;
  localparam int FRAC_MASK  = (1 << FRAC_SHIFT) - 1;

  // Clamp limits and register reset value.
  localparam logic [9:0] ANGLE_LIMIT     = 10'd200;
  localparam logic [9:0] MAX_PITCH_RESET = 10'd200;

  // Mode codes of a request beat.
  localparam logic [1:0] MODE_STORE   = 2'd0;
  localparam logic [1:0] MODE_COMPUTE = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               zoomed_in;
  } req_beat_t;

  typedef struct packed {
    logic signed [8:0]  zoom_angle;
    logic signed [10:0] zoom_pitch;
    logic               angles_updated;
    logic               reference_set;
  } rsp_beat_t;

  // What an accepted beat does further down the pipeline.
  typedef struct packed {
    logic store;
    logic capture;
    logic update;
    logic ref_set;
  } op_t;

endpackage

// ===== src/taza_ring.sv =====
// ----------------------------------------------------------------------------
// Tilt average zoom angles: sample ring
// Sample memory with registered read, running sums, reference capture and the
// average-minus-reference differences for the tilt stage.
// ----------------------------------------------------------------------------
module taza_ring #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          rd_en,
  input  logic [taza_pkg::RING_AW-1:0]  rd_idx,
  input  logic                          s1_valid,
  input  taza_pkg::op_t                 s1_op,
  input  logic [taza_pkg::RING_AW-1:0]  s1_idx,
  input  logic signed [SAMPLE_BITS-1:0] s1_x,
  input  logic signed [SAMPLE_BITS-1:0] s1_y,
  output logic signed [SAMPLE_BITS:0]   diff_x,
  output logic signed [SAMPLE_BITS:0]   diff_y
);
  import taza_pkg::*;

  localparam int SW = SAMPLE_BITS + RING_AW;
  localparam int MW = 2 * SAMPLE_BITS;

  logic [MW-1:0]                 mem [RING_DEPTH];
  logic [RING_DEPTH-1:0]         entry_vld;
  logic [MW-1:0]                 rd_data;
  logic [MW-1:0]                 wr_data;
  logic                          wr_en;
  logic signed [SAMPLE_BITS-1:0] old_x;
  logic signed [SAMPLE_BITS-1:0] old_y;
  logic signed [SW-1:0]          sum_x;
  logic signed [SW-1:0]          sum_y;
  logic signed [SAMPLE_BITS-1:0] avg_x;
  logic signed [SAMPLE_BITS-1:0] avg_y;
  logic signed [SAMPLE_BITS-1:0] ref_x;
  logic signed [SAMPLE_BITS-1:0] ref_y;

  // A store writes its sample back when it advances out of stage one, after its read.
  assign wr_en   = advance && s1_valid && s1_op.store;
  assign wr_data = {s1_x, s1_y};

  // The z axis never reaches a result, so only x and y are kept.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_idx] <= wr_data;
    end
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
    end else if (wr_en) begin
      entry_vld[s1_idx] <= 1'b1;
    end
  end

  // Registered read, with the write of the same edge forwarded.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (s1_idx == rd_idx)) begin
        rd_data <= wr_data;
      end else if (entry_vld[rd_idx]) begin
        rd_data <= mem[rd_idx];
      end else begin
        rd_data <= '0;
      end
    end
  end

  assign old_x = $signed(rd_data[MW-1:SAMPLE_BITS]);
  assign old_y = $signed(rd_data[SAMPLE_BITS-1:0]);

  // Running sums: add the new sample, drop the one it replaces.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x <= '0;
      sum_y <= '0;
    end else if (wr_en) begin
      sum_x <= sum_x + SW'(s1_x) - SW'(old_x);
      sum_y <= sum_y + SW'(s1_y) - SW'(old_y);
    end
  end

  // Floor average over the ring is an arithmetic shift.
  assign avg_x = $signed(sum_x[SW-1:RING_AW]);
  assign avg_y = $signed(sum_y[SW-1:RING_AW]);

  // The first qualifying compute takes the averages as reference.
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_x <= '0;
      ref_y <= '0;
    end else if (advance && s1_valid && s1_op.capture) begin
      ref_x <= avg_x;
      ref_y <= avg_y;
    end
  end

  assign diff_x = (SAMPLE_BITS + 1)'(avg_x) - (SAMPLE_BITS + 1)'(ref_x);
  assign diff_y = (SAMPLE_BITS + 1)'(avg_y) - (SAMPLE_BITS + 1)'(ref_y);

endmodule

// ===== src/taza_tilt.sv =====
// ----------------------------------------------------------------------------
// Tilt average zoom angles: tilt scaler
// Scales a difference by the tilt gain, truncates toward zero and clamps it
// to a symmetric limit.
// ----------------------------------------------------------------------------
module taza_tilt #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic signed [SAMPLE_BITS:0] diff,
  input  logic [9:0]                  limit,
  output logic signed [10:0]          tilt
);
  import taza_pkg::*;

  localparam int PW = SAMPLE_BITS + 11;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] bias;
  logic signed [PW-1:0] quot;
  logic signed [PW-1:0] lim_pos;
  logic signed [PW-1:0] lim_neg;
  logic signed [PW-1:0] clamped;

  // Gain multiply, then a biased shift so negative values round toward zero.
  assign prod = PW'(diff) * PW'(TILT_GAIN);
  assign bias = prod[PW-1] ? PW'(FRAC_MASK) : '0;
  assign quot = (prod + bias) >>> FRAC_SHIFT;

  assign lim_pos = $signed(PW'(limit));
  assign lim_neg = -lim_pos;

  // Symmetric clamp.
  always_comb begin
    if (quot > lim_pos) begin
      clamped = lim_pos;
    end else if (quot < lim_neg) begin
      clamped = lim_neg;
    end else begin
      clamped = quot;
    end
  end

  assign tilt = clamped[10:0];

endmodule

// ===== src/tilt_average_zoom_angles.sv =====
// ----------------------------------------------------------------------------
// Tilt average zoom angles: top level
// Averages accelerometer samples over a ring and reports clamped angle and
// pitch relative to a captured reference.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats (req_valid/req_ready, payload req) carry a mode: store a
//   sample, compute angles, or restart tracking. Every request beat yields
//   exactly one response beat (rsp_valid/rsp_ready, payload rsp), in order.
//   max_pitch is written through cfg_wr_en/cfg_wr_data while the block is
//   idle; it resets to 200.
//   Throughput is one beat per cycle while the receiver does not stall.
//   The accepting edge registers the beat in stage one with its ring memory
//   read, the running sums and reference subtraction feed the stage two
//   register, and the gain multiply and clamp fill the output register.
//   Reset clears the ring (through per-entry valid bits), the sums, the
//   reference, the held angle and pitch, the tracking state and the
//   pipeline valid bits; the block is ready for a request once reset ends.
//   When the receiver stalls, the whole pipeline holds and req_ready drops;
//   the response register is never overwritten while it waits.
// ----------------------------------------------------------------------------
module tilt_average_zoom_angles #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  taza_pkg::req_beat_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output taza_pkg::rsp_beat_t rsp,
  input  logic                cfg_wr_en,
  input  logic [9:0]          cfg_wr_data
);
  import taza_pkg::*;

  logic                          advance;
  logic                          accept;
  logic [RING_AW-1:0]            write_index;
  logic [RING_AW-1:0]            write_index_next;
  logic                          ring_full;
  logic                          ring_full_next;
  logic                          ref_taken;
  logic                          ref_taken_next;
  op_t                           op0;
  logic signed [SAMPLE_BITS-1:0] smp_x;
  logic signed [SAMPLE_BITS-1:0] smp_y;
  logic [9:0]                    max_pitch;

  logic                          s1_valid;
  op_t                           s1_op;
  logic [RING_AW-1:0]            s1_idx;
  logic signed [SAMPLE_BITS-1:0] s1_x;
  logic signed [SAMPLE_BITS-1:0] s1_y;
  logic signed [SAMPLE_BITS:0]   diff_x;
  logic signed [SAMPLE_BITS:0]   diff_y;

  logic                          s2_valid;
  op_t                           s2_op;
  logic signed [SAMPLE_BITS:0]   s2_diff_x;
  logic signed [SAMPLE_BITS:0]   s2_diff_y;
  logic signed [10:0]            angle_tilt;
  logic signed [10:0]            pitch_tilt;
  logic signed [8:0]             angle_reg;
  logic signed [10:0]            pitch_reg;

  // The pipeline moves whenever the response register is free or drained.
  assign advance   = !rsp_valid || rsp_ready;
  assign req_ready = advance;
  assign accept    = req_valid && advance;

  // Samples are the low SAMPLE_BITS of each field, sign extended.
  assign smp_x = SAMPLE_BITS'(req.accel_x);
  assign smp_y = SAMPLE_BITS'(req.accel_y);

  // Tracking state and the operation of the incoming beat.
  always_comb begin
    write_index_next = write_index;
    ring_full_next   = ring_full;
    ref_taken_next   = ref_taken;
    op0              = '0;
    case (req.mode)
      MODE_STORE: begin
        op0.store        = 1'b1;
        write_index_next = write_index + 1'b1;
        if (write_index_next == '0) begin
          ring_full_next = 1'b1;
        end
      end
      MODE_COMPUTE: begin
        if (ring_full && req.zoomed_in) begin
          if (!ref_taken) begin
            op0.capture    = 1'b1;
            ref_taken_next = 1'b1;
          end else begin
            op0.update = 1'b1;
          end
        end
      end
      MODE_RESTART: begin
        write_index_next = '0;
        ring_full_next   = 1'b0;
        ref_taken_next   = 1'b0;
      end
      default: begin
      end
    endcase
    op0.ref_set = ref_taken_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      ring_full   <= 1'b0;
      ref_taken   <= 1'b0;
    end else if (accept) begin
      write_index <= write_index_next;
      ring_full   <= ring_full_next;
      ref_taken   <= ref_taken_next;
    end
  end

  // Pitch clamp register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_pitch <= MAX_PITCH_RESET;
    end else if (cfg_wr_en) begin
      max_pitch <= cfg_wr_data;
    end
  end

  // Stage one: beat waits for its ring read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op  <= op0;
      s1_idx <= write_index;
      s1_x   <= smp_x;
      s1_y   <= smp_y;
    end
  end

  taza_ring #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .rd_en   (accept && op0.store),
    .rd_idx  (write_index),
    .s1_valid(s1_valid),
    .s1_op   (s1_op),
    .s1_idx  (s1_idx),
    .s1_x    (s1_x),
    .s1_y    (s1_y),
    .diff_x  (diff_x),
    .diff_y  (diff_y)
  );

  // Stage two: differences held for the tilt multiply.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_op     <= s1_op;
      s2_diff_x <= diff_x;
      s2_diff_y <= diff_y;
    end
  end

  taza_tilt #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_tilt_angle (
    .diff (s2_diff_x),
    .limit(ANGLE_LIMIT),
    .tilt (angle_tilt)
  );

  taza_tilt #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_tilt_pitch (
    .diff (s2_diff_y),
    .limit(max_pitch),
    .tilt (pitch_tilt)
  );

  // Held angle and pitch change only on an update.
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_reg <= '0;
      pitch_reg <= '0;
    end else if (advance && s2_valid && s2_op.update) begin
      angle_reg <= angle_tilt[8:0];
      pitch_reg <= pitch_tilt;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid) begin
      rsp.zoom_angle     <= s2_op.update ? angle_tilt[8:0] : angle_reg;
      rsp.zoom_pitch     <= s2_op.update ? pitch_tilt : pitch_reg;
      rsp.angles_updated <= s2_op.update;
      rsp.reference_set  <= s2_op.ref_set;
    end
  end

endmodule

// ===== src/taza_checker.sv =====
// ----------------------------------------------------------------------------
// Tilt average zoom angles: port checker
// Watches the top level's ports and flags behaviour the block must never show.
// ----------------------------------------------------------------------------
`include "tilt_average_zoom_angles_macros.svh"

module taza_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input taza_pkg::req_beat_t req,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input taza_pkg::rsp_beat_t rsp
);
  import taza_pkg::*;

  // A stalled response beat stays put.
  `TAZA_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response changed while stalled")

  // With no response pending the block must take requests.
  `TAZA_ASSERT_SAME(a_ready_free, clk, rst, !rsp_valid, req_ready, "request refused with empty output")

  // New angles only come after a reference has been captured.
  `TAZA_ASSERT_SAME(a_upd_ref, clk, rst, rsp_valid && rsp.angles_updated, rsp.reference_set, "angles updated without a reference")

  // The angle never leaves its clamp range.
  `TAZA_ASSERT_SAME(a_angle_range, clk, rst, rsp_valid, (rsp.zoom_angle <= 9'sd200) && (rsp.zoom_angle >= -9'sd200), "angle outside clamp range")

endmodule

bind tilt_average_zoom_angles taza_checker u_taza_checker (.*);

// ===== dv/tilt_average_zoom_angles_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tilt average zoom angles: testbench
// Feeds store, compute, restart and unused-mode beats through the request
// channel while both sides idle at random. A model of the ring, the running
// sums and the reference predicts every response beat, and the monitor checks
// each response field by field, in order. The pitch limit is rewritten
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tilt_average_zoom_angles_test;
  import taza_pkg::*;

  // Mode code that the block must treat as a no-op.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         IDLE_PCT    = 19;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_beat_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_beat_t rsp;
  logic       cfg_wr_en = 1'b0;
  logic [9:0] cfg_wr_data = '0;

  // Beats waiting to be driven, and responses awaited from the block.
  req_beat_t pending_reqs[$];
  rsp_beat_t awaited_rsps[$];
  int        mismatches = 0;
  logic      steady = 1'b0;

  // Model state: ring, sums, reference, held outputs and the pitch limit.
  logic signed [15:0]  ring_store [RING_DEPTH][3] = '{default: '0};
  logic [RING_AW-1:0]  wr_idx = '0;
  logic                ring_full = 1'b0;
  logic                ref_taken = 1'b0;
  logic signed [20:0]  axis_sums [3] = '{default: '0};
  logic signed [15:0]  ref_avgs [3] = '{default: '0};
  logic signed [8:0]   held_angle = '0;
  logic signed [10:0]  held_pitch = '0;
  logic [9:0]          pitch_limit = MAX_PITCH_RESET;

  tilt_average_zoom_angles uut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // Scaled tilt of an average difference, truncated toward zero and clamped.
  function automatic int tilt_of(int diff, int limit);
    int q;
    q = (diff * TILT_GAIN) / (1 << FRAC_SHIFT);
    if (q > limit) q = limit;
    if (q < -limit) q = -limit;
    return q;
  endfunction

  // Advances the model by one request beat and returns the response it gives.
  function automatic rsp_beat_t predict_angles(req_beat_t b);
    logic signed [15:0] smp [3];
    logic signed [15:0] avg [3];
    rsp_beat_t r;
    int a;
    r = '0;
    case (b.mode)
      MODE_STORE: begin
        smp[0] = b.accel_x;
        smp[1] = b.accel_y;
        smp[2] = b.accel_z;
        for (a = 0; a < 3; a++) begin
          axis_sums[a] = axis_sums[a] + smp[a] - ring_store[wr_idx][a];
          ring_store[wr_idx][a] = smp[a];
        end
        wr_idx = wr_idx + 1'b1;
        if (wr_idx == '0) ring_full = 1'b1;
      end
      MODE_COMPUTE: begin
        if (ring_full && b.zoomed_in) begin
          for (a = 0; a < 3; a++) avg[a] = 16'(axis_sums[a] >>> RING_AW);
          if (!ref_taken) begin
            ref_taken = 1'b1;
            for (a = 0; a < 3; a++) ref_avgs[a] = avg[a];
          end else begin
            held_angle = 9'(tilt_of(int'(avg[0]) - int'(ref_avgs[0]), int'(ANGLE_LIMIT)));
            held_pitch = 11'(tilt_of(int'(avg[1]) - int'(ref_avgs[1]), int'(pitch_limit)));
            r.angles_updated = 1'b1;
          end
        end
      end
      MODE_RESTART: begin
        wr_idx = '0;
        ring_full = 1'b0;
        ref_taken = 1'b0;
      end
      default: ;
    endcase
    r.zoom_angle = held_angle;
    r.zoom_pitch = held_pitch;
    r.reference_set = ref_taken;
    return r;
  endfunction

  // Request driver: a new beat only once the current one has been taken.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        req <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response stalls.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: predict on each accepted request, check each accepted response.
  always @(posedge clk) begin
    rsp_beat_t want;
    if (!rst) begin
      if (req_valid && req_ready) awaited_rsps.push_back(predict_angles(req));
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected response beat: angle %0d pitch %0d upd %0b ref %0b",
                     rsp.zoom_angle, rsp.zoom_pitch, rsp.angles_updated, rsp.reference_set);
        end else begin
          want = awaited_rsps.pop_front();
          if (rsp.zoom_angle !== want.zoom_angle || rsp.zoom_pitch !== want.zoom_pitch ||
              rsp.angles_updated !== want.angles_updated ||
              rsp.reference_set !== want.reference_set) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: want a %0d p %0d u %0b r %0b, got a %0d p %0d u %0b r %0b",
                       want.zoom_angle, want.zoom_pitch, want.angles_updated,
                       want.reference_set, rsp.zoom_angle, rsp.zoom_pitch,
                       rsp.angles_updated, rsp.reference_set);
          end
        end
      end
    end
  end

  task automatic push_req(logic [1:0] mode, logic [15:0] x, logic [15:0] y,
                          logic [15:0] z, logic zoom);
    req_beat_t b;
    b.mode = mode;
    b.accel_x = x;
    b.accel_y = y;
    b.accel_z = z;
    b.zoomed_in = zoom;
    pending_reqs.push_back(b);
  endtask

  // A sample scattered around a level, saturated to the 16-bit range.
  function automatic logic [15:0] sample_near(int level, int spread);
    int v;
    v = level + $urandom_range(2 * spread) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic int pick_level();
    case ($urandom_range(7))
      0: return 32767;
      1: return -32768;
      2: return 0;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  // Random session: mostly store bursts around a level, then computes, with
  // restarts, unused modes and computes that cannot act mixed in.
  task automatic queue_session(int count);
    int added;
    int run_len;
    int spread;
    int lx, ly, lz;
    int k;
    added = 0;
    while (added < count) begin
      k = $urandom_range(99);
      if (k < 55) begin
        run_len = $urandom_range(1, 40);
        spread = ($urandom_range(3) == 0) ? 32767 : $urandom_range(4096);
        lx = pick_level();
        ly = pick_level();
        lz = pick_level();
        repeat (run_len)
          push_req(MODE_STORE, sample_near(lx, spread), sample_near(ly, spread),
                   sample_near(lz, spread), 1'($urandom()));
        added += run_len;
      end else if (k < 90) begin
        push_req(MODE_COMPUTE, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                 $urandom_range(99) < 85);
        added++;
      end else if (k < 94) begin
        push_req(MODE_RESTART, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                 1'($urandom()));
        added++;
      end else begin
        push_req(MODE_UNUSED, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                 1'($urandom()));
        added++;
      end
    end
  endtask

  // Block until every beat has been driven and answered, then let it settle.
  task automatic wait_quiet();
    while (pending_reqs.size() != 0 || req_valid || awaited_rsps.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_pitch_limit(logic [9:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    pitch_limit = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Phases: reset limit with directed beats, then the extremes and a random
  // limit, one phase running without any idling.
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Computes before the ring is full, the unused mode and a restart.
    push_req(MODE_COMPUTE, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b1);
    push_req(MODE_COMPUTE, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    push_req(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    push_req(MODE_UNUSED, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    push_req(MODE_RESTART, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
    // Sample extremes on every axis.
    push_req(MODE_STORE, 16'h7FFF, 16'h8000, 16'h0000, 1'b0);
    push_req(MODE_STORE, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b1);
    push_req(MODE_STORE, 16'hFFFF, 16'h0001, 16'h7FFF, 1'b0);
    push_req(MODE_STORE, 16'h0000, 16'hFFFF, 16'h8000, 1'b1);
    push_req(MODE_STORE, 16'h0001, 16'h0000, 16'h0001, 1'b0);
    push_req(MODE_COMPUTE, 16'h1234, 16'h5678, 16'h9ABC, 1'b1);
    push_req(MODE_RESTART, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    push_req(MODE_STORE, 16'h4000, 16'hC000, 16'h1000, 1'b0);
    queue_session(90);
    wait_quiet();

    write_pitch_limit(10'd0);
    queue_session(90);
    wait_quiet();

    write_pitch_limit(10'd1023);
    steady = 1'b1;
    queue_session(90);
    wait_quiet();
    steady = 1'b0;

    write_pitch_limit(10'($urandom_range(1, 1022)));
    queue_session(90);
    wait_quiet();

    write_pitch_limit(10'd1);
    queue_session(90);
    wait_quiet();
    repeat (10) @(posedge clk);

    if (mismatches == 0 && awaited_rsps.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
